@@ src/mtsb_pkg.sv @@
// shared types and constants for the mesh time sync blinker
// no dependencies
package mtsb_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int GAP_WIDTH  = 14;
  localparam int DRAW_WIDTH = 16;
  localparam int PER_WIDTH  = 16;
  localparam int CNT_WIDTH  = 5;

  localparam logic [1:0] REG_BLINK_PERIOD   = 2'd0;
  localparam logic [1:0] REG_LAG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_STARTUP_WINDOW = 2'd2;

  localparam logic [PER_WIDTH-1:0]  BLINK_PERIOD_RST   = 16'd645;
  localparam logic [PER_WIDTH-1:0]  LAG_THRESHOLD_RST  = 16'd10;
  localparam logic [TIME_WIDTH-1:0] STARTUP_WINDOW_RST = 32'd60000;

  localparam logic [GAP_WIDTH-1:0] FAST_LOW   = 14'd200;
  localparam logic [GAP_WIDTH-1:0] FAST_SPAN  = 14'd100;
  localparam logic [GAP_WIDTH-1:0] SLOW_LOW   = 14'd800;
  localparam logic [GAP_WIDTH-1:0] SLOW_SPAN  = 14'd400;
  localparam logic [GAP_WIDTH-1:0] SYNC_LOW   = 14'd10000;
  localparam logic [GAP_WIDTH-1:0] SYNC_SPAN  = 14'd2000;
  localparam logic [GAP_WIDTH-1:0] REPLY_LOW  = 14'd10;
  localparam logic [GAP_WIDTH-1:0] REPLY_SPAN = 14'd90;

  localparam logic [CNT_WIDTH-1:0] DRAW_STEPS = CNT_WIDTH'(DRAW_WIDTH - 1);
  localparam logic [CNT_WIDTH-1:0] TIME_STEPS = CNT_WIDTH'(TIME_WIDTH - 1);

  localparam logic OP_TICK = 1'b0;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADV  = 7'b0000010,
    S_MESH = 7'b0000100,
    S_DEC  = 7'b0001000,
    S_GAP  = 7'b0010000,
    S_BLK  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

@@ src/mesh_time_sync_blinker.sv @@
// mesh time sync blinker top level: sequencer around one shared remainder unit
// depends on mtsb_pkg
//
// usage: s_* takes one request per item; s_tuser is the operation (0 tick,
// 1 time received), s_tdata carries received_time and random_draw. m_* gives
// exactly one result per request: send_valid, send_time and the blink level.
// cfg_we/cfg_index/cfg_data write blink_period (0), lag_threshold (1) and
// startup_window (2); write only while the block is idle.
// steps: advance the counter, form the mesh time and decide; then the interval
// draw remainder when a new interval is chosen, then the mesh time remainder by
// the blink period (skipped for a zero period), then load the output register.
// both modulo steps use the bit-serial remainder unit that they share. one item
// at a time: the next request is taken only after the result is loaded.
// s_tready is high only while idle; a finished result sits in the output
// register, so the next request is taken while it waits, and the block holds
// in its last step until the previous result is taken.
// reset clears the time state, loads the register defaults and empties the
// output register.
module mesh_time_sync_blinker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // received_time[31:0], random_draw[47:32]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // send_valid[0], send_time[32:1], blink[33], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TW = mtsb_pkg::TIME_WIDTH;
  localparam int GW = mtsb_pkg::GAP_WIDTH;
  localparam int PW = mtsb_pkg::PER_WIDTH;
  localparam int DW = mtsb_pkg::DRAW_WIDTH;
  localparam int CW = mtsb_pkg::CNT_WIDTH;

  mtsb_pkg::state_t state;

  logic [PW-1:0] blink_period;
  logic [PW-1:0] lag_threshold;
  logic [TW-1:0] startup_window;

  logic [TW-1:0] local_ms;
  logic [TW-1:0] mesh_offset;
  logic [TW-1:0] last_send_ms;
  logic [GW-1:0] send_gap;

  logic          op;
  logic [TW-1:0] rx;
  logic [DW-1:0] draw;
  logic [TW-1:0] mesh;
  logic [TW-1:0] gap_diff;
  logic          send;
  logic          blink;
  logic [GW-1:0] gap_low;

  // shared remainder unit
  logic [TW-1:0] dvd;
  logic [PW-1:0] dsr;
  logic [PW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [PW:0]   rem_s;
  logic [PW:0]   rem_sub;
  logic [PW-1:0] rem_next;

  assign rem_s    = {rem, dvd[TW-1]};
  assign rem_sub  = rem_s - {1'b0, dsr};
  assign rem_next = (rem_s >= {1'b0, dsr}) ? rem_sub[PW-1:0] : rem_s[PW-1:0];

  // decision terms
  logic          rx_ahead;
  logic [TW-1:0] lag;
  logic          lag_hit;
  logic          gap_due;
  logic          out_free;

  assign rx_ahead = rx > mesh;
  assign lag      = mesh - rx;
  assign lag_hit  = lag >= {{(TW-PW){1'b0}}, lag_threshold};
  assign gap_due  = gap_diff >= {{(TW-GW){1'b0}}, send_gap};
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == mtsb_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period   <= mtsb_pkg::BLINK_PERIOD_RST;
      lag_threshold  <= mtsb_pkg::LAG_THRESHOLD_RST;
      startup_window <= mtsb_pkg::STARTUP_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtsb_pkg::REG_BLINK_PERIOD:   blink_period   <= cfg_data[PW-1:0];
        mtsb_pkg::REG_LAG_THRESHOLD:  lag_threshold  <= cfg_data[PW-1:0];
        mtsb_pkg::REG_STARTUP_WINDOW: startup_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mtsb_pkg::S_IDLE;
      local_ms     <= '0;
      mesh_offset  <= '0;
      last_send_ms <= '0;
      send_gap     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // the output step reloads the register itself when it is free
      if (m_tready && state != mtsb_pkg::S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        mtsb_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            rx    <= s_tdata[TW-1:0];
            draw  <= s_tdata[TW+DW-1:TW];
            send  <= 1'b0;
            state <= mtsb_pkg::S_ADV;
          end
        end
        mtsb_pkg::S_ADV: begin
          if (op == mtsb_pkg::OP_TICK) begin
            local_ms <= local_ms + TW'(1);
          end
          state <= mtsb_pkg::S_MESH;
        end
        mtsb_pkg::S_MESH: begin
          mesh     <= local_ms + mesh_offset;
          gap_diff <= local_ms - last_send_ms;
          state    <= mtsb_pkg::S_DEC;
        end
        mtsb_pkg::S_DEC: begin
          // default: go straight to the blink remainder
          dvd <= mesh;
          dsr <= blink_period;
          rem <= '0;
          cnt <= mtsb_pkg::TIME_STEPS;
          if (blink_period == '0) begin
            blink <= 1'b0;
            state <= mtsb_pkg::S_OUT;
          end else begin
            state <= mtsb_pkg::S_BLK;
          end
          if (op == mtsb_pkg::OP_TICK) begin
            if (gap_due) begin
              last_send_ms <= local_ms;
              send         <= 1'b1;
              dvd          <= {draw, {(TW-DW){1'b0}}};
              rem          <= '0;
              cnt          <= mtsb_pkg::DRAW_STEPS;
              state        <= mtsb_pkg::S_GAP;
              if (mesh_offset != '0) begin
                gap_low <= mtsb_pkg::SYNC_LOW;
                dsr     <= PW'(mtsb_pkg::SYNC_SPAN);
              end else if (local_ms < startup_window) begin
                gap_low <= mtsb_pkg::FAST_LOW;
                dsr     <= PW'(mtsb_pkg::FAST_SPAN);
              end else begin
                gap_low <= mtsb_pkg::SLOW_LOW;
                dsr     <= PW'(mtsb_pkg::SLOW_SPAN);
              end
            end
          end else if (rx_ahead) begin
            mesh_offset <= rx - local_ms;
            mesh        <= rx;
            dvd         <= rx;
          end else if (lag_hit) begin
            if (mesh_offset == '0) begin
              send <= 1'b1;
            end else begin
              last_send_ms <= local_ms;
              gap_low      <= mtsb_pkg::REPLY_LOW;
              dsr          <= PW'(mtsb_pkg::REPLY_SPAN);
              dvd          <= {draw, {(TW-DW){1'b0}}};
              rem          <= '0;
              cnt          <= mtsb_pkg::DRAW_STEPS;
              state        <= mtsb_pkg::S_GAP;
            end
          end
        end
        mtsb_pkg::S_GAP: begin
          rem <= rem_next;
          dvd <= {dvd[TW-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            send_gap <= gap_low + rem_next[GW-1:0];
            dvd      <= mesh;
            dsr      <= blink_period;
            rem      <= '0;
            cnt      <= mtsb_pkg::TIME_STEPS;
            if (blink_period == '0) begin
              blink <= 1'b0;
              state <= mtsb_pkg::S_OUT;
            end else begin
              state <= mtsb_pkg::S_BLK;
            end
          end
        end
        mtsb_pkg::S_BLK: begin
          rem <= rem_next;
          dvd <= {dvd[TW-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            blink <= {rem_next, 1'b0} >= {1'b0, dsr};
            state <= mtsb_pkg::S_OUT;
          end
        end
        mtsb_pkg::S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, blink, (send ? mesh : {TW{1'b0}}), send};
            state    <= mtsb_pkg::S_IDLE;
          end
        end
        default: state <= mtsb_pkg::S_IDLE;
      endcase
    end
  end

  // a request always starts the counter step
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == mtsb_pkg::S_ADV)
    else $error("request did not start the sequence");

  // the remainder unit never runs with a zero divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == mtsb_pkg::S_GAP || state == mtsb_pkg::S_BLK) |-> dsr != '0)
    else $error("remainder unit running with zero divisor");

  // no send means a zero send time
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
    else $error("send time without send");

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result lost");

endmodule
